/* sv/bbds_pkg.sv */
// Shared types, constants and ordering helper for the deadline scheduler.
package bbds_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W   = $clog2(DEPTH + 1);
  localparam int FIELD_W = 15;
  localparam int RANK_W  = 2 * FIELD_W;
  localparam int CAP_W   = 5;

  localparam logic POLICY_EDF = 1'b0;
  localparam logic POLICY_BD  = 1'b1;

  localparam logic MODE_ARRIVE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  localparam logic REG_POLICY   = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  typedef struct packed {
    logic load;
    logic fill;
    logic ev_scan;
    logic ev_write;
    logic tick_scan;
    logic finish;
  } bbds_cmd_t;

  typedef struct packed {
    logic last;
    logic ev_ok;
    logic batch_ok;
  } bbds_stat_t;

  // Primary key in the upper half, the other field breaks ties.
  function automatic logic [RANK_W-1:0] rank_of(input logic pol,
                                                input logic [FIELD_W-1:0] s,
                                                input logic [FIELD_W-1:0] v);
    rank_of = (pol == POLICY_BD) ? {v, s} : {s, v};
  endfunction

endpackage

/* sv/bounded_buffer_deadline_scheduler.sv */
// Top level of the bounded buffer deadline scheduler: config port and core.
//
//  channel   signals                                   word accepted when
//  input     start, mode, amount, slack, value         start && !busy
//  result    done, dropped_now .. total_value          done (one cycle only)
//  config    psel, penable, pwrite, paddr, pwdata      psel && penable && pwrite
//
// An arrival passes through load, a fill pass, then one scan-and-decide round
// per eviction (at most DEPTH of them, plus the final round that stops), then
// finish; an invalid batch goes from the fill state straight to finish. A tick
// passes through load, one aging pass and finish. The result strobe comes the
// cycle after finish. Each pass is a single sequential scan over the entry
// buffer. Reset clears the entries' valid bits, totals and the sequencer at
// once. The receiver cannot stall: each result word shows once.
module bounded_buffer_deadline_scheduler import bbds_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [15:0] amount,
  input  logic [15:0] slack,
  input  logic [15:0] value,
  // result channel
  output logic        done,
  output logic [16:0] dropped_now,
  output logic        sent,
  output logic [14:0] sent_value,
  output logic [4:0]  occupancy,
  output logic [31:0] total_arrived,
  output logic [31:0] total_dropped,
  output logic [31:0] total_sent,
  output logic [31:0] total_value,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic             policy;
  logic [CAP_W-1:0] capacity;
  logic             reg_sel;
  bbds_cmd_t        cmd;
  bbds_stat_t       stat;

  // register index is the word address
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy   <= POLICY_EDF;
      capacity <= CAP_W'(16);
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_POLICY:   policy   <= pwdata[0];
        REG_CAPACITY: capacity <= pwdata[CAP_W-1:0];
        default:      policy   <= policy;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_POLICY:   prdata = {31'd0, policy};
      REG_CAPACITY: prdata = {27'd0, capacity};
      default:      prdata = '0;
    endcase
  end

  // sequencer: walks fill, eviction and tick passes
  bbds_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // datapath: entries, scan index, totals, result word
  bbds_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .policy        (policy),
    .capacity      (capacity),
    .mode          (mode),
    .amount        (amount),
    .slack         (slack),
    .value         (value),
    .done          (done),
    .dropped_now   (dropped_now),
    .sent          (sent),
    .sent_value    (sent_value),
    .occupancy     (occupancy),
    .total_arrived (total_arrived),
    .total_dropped (total_dropped),
    .total_sent    (total_sent),
    .total_value   (total_value)
  );

endmodule

/* sv/bbds_ctrl.sv */
// Sequencer for fill, eviction and tick passes over the entry buffer.
module bbds_ctrl import bbds_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       mode,
  input  bbds_stat_t stat,
  output bbds_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [2:0] {
    S_IDLE, S_FILL, S_EVSCAN, S_EVDEC, S_TICK, S_FINISH
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = (mode == MODE_TICK) ? S_TICK : S_FILL;
        end
      end
      S_FILL: begin
        if (!stat.batch_ok) begin
          state_next = S_FINISH;
        end else begin
          cmd.fill = 1'b1;
          if (stat.last) state_next = S_EVSCAN;
        end
      end
      S_EVSCAN: begin
        cmd.ev_scan = 1'b1;
        if (stat.last) state_next = S_EVDEC;
      end
      S_EVDEC: begin
        if (stat.ev_ok) begin
          cmd.ev_write = 1'b1;
          state_next   = S_EVSCAN;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_TICK: begin
        cmd.tick_scan = 1'b1;
        if (stat.last) state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  a_tick_path: assert property (@(posedge clk) disable iff (rst)
    (state == S_TICK && stat.last) |=> (state == S_FINISH))
    else $error("tick pass did not end in finish");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (state == S_IDLE))
    else $error("word loaded while busy");
  a_evict_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVDEC) |-> $past(state == S_EVSCAN))
    else $error("eviction decision without scan");

endmodule

/* sv/bbds_dp.sv */
// Entry buffer, scan index, running totals and result registers.
module bbds_dp import bbds_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  bbds_cmd_t        cmd,
  output bbds_stat_t       stat,
  input  logic             policy,
  input  logic [CAP_W-1:0] capacity,
  input  logic             mode,
  input  logic [15:0]      amount,
  input  logic [15:0]      slack,
  input  logic [15:0]      value,
  output logic             done,
  output logic [16:0]      dropped_now,
  output logic             sent,
  output logic [14:0]      sent_value,
  output logic [4:0]       occupancy,
  output logic [31:0]      total_arrived,
  output logic [31:0]      total_dropped,
  output logic [31:0]      total_sent,
  output logic [31:0]      total_value
);

  logic [FIELD_W-1:0] slack_mem [DEPTH];
  logic [FIELD_W-1:0] value_mem [DEPTH];
  logic [DEPTH-1:0]   valid;

  logic [IDX_W-1:0]   idx, best;
  logic [RANK_W-1:0]  best_rank;
  logic               found;
  logic [OCC_W-1:0]   occ;
  logic [15:0]        left;
  logic [16:0]        drops;
  logic               tick;
  logic [FIELD_W-1:0] s_in, v_in;
  logic               batch_ok;

  logic [OCC_W-1:0]   cap;
  logic               last;
  logic [FIELD_W-1:0] aged;
  logic [RANK_W-1:0]  cur_rank, aged_rank;
  logic [FIELD_W-1:0] new_key, best_key, best_val;
  logic [16:0]        drops_sum;

  always_comb begin
    if (OCC_W'(capacity) > OCC_W'(DEPTH) || 32'(capacity) > DEPTH) cap = OCC_W'(DEPTH);
    else cap = OCC_W'(capacity);
  end

  assign last      = (32'(idx) == DEPTH - 1);
  assign aged      = slack_mem[idx] - FIELD_W'(1);
  assign cur_rank  = rank_of(policy, slack_mem[idx], value_mem[idx]);
  assign aged_rank = rank_of(policy, aged, value_mem[idx]);
  assign new_key   = (policy == POLICY_BD) ? v_in : s_in;
  assign best_key  = best_rank[RANK_W-1:FIELD_W];
  assign best_val  = (policy == POLICY_BD) ? best_rank[RANK_W-1:FIELD_W]
                                           : best_rank[FIELD_W-1:0];
  assign drops_sum = drops + {1'b0, left};

  assign stat.last     = last;
  assign stat.ev_ok    = found && (left != '0) && (best_key < new_key);
  assign stat.batch_ok = batch_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= '0;
      idx           <= '0;
      found         <= 1'b0;
      occ           <= '0;
      done          <= 1'b0;
      total_arrived <= '0;
      total_dropped <= '0;
      total_sent    <= '0;
      total_value   <= '0;
    end else begin
      done <= cmd.finish;
      if (cmd.fill || cmd.ev_scan || cmd.tick_scan) begin
        idx <= last ? '0 : idx + IDX_W'(1);
      end
      if (cmd.load) begin
        idx           <= '0;
        found         <= 1'b0;
        drops         <= '0;
        tick          <= (mode == MODE_TICK);
        left          <= (mode == MODE_TICK) ? 16'd0 : amount;
        s_in          <= slack[FIELD_W-1:0];
        v_in          <= value[FIELD_W-1:0];
        batch_ok      <= (slack != '0) && !slack[15] && (value != '0) && !value[15];
        if (mode == MODE_ARRIVE) total_arrived <= total_arrived + 32'(amount);
      end
      // take the lowest free entry while room and packets remain
      if (cmd.fill && !valid[idx] && (occ < cap) && (left != '0)) begin
        valid[idx]     <= 1'b1;
        slack_mem[idx] <= s_in;
        value_mem[idx] <= v_in;
        occ            <= occ + OCC_W'(1);
        left           <= left - 16'd1;
      end
      if (cmd.ev_scan && valid[idx] && (!found || cur_rank < best_rank)) begin
        found     <= 1'b1;
        best      <= idx;
        best_rank <= cur_rank;
      end
      // replace the minimum entry; drop it
      if (cmd.ev_write) begin
        slack_mem[best] <= s_in;
        value_mem[best] <= v_in;
        left            <= left - 16'd1;
        drops           <= drops + 17'd1;
        found           <= 1'b0;
      end
      // age, expire, and track the send candidate on the aged slack
      if (cmd.tick_scan && valid[idx]) begin
        slack_mem[idx] <= aged;
        if (aged == '0) begin
          valid[idx] <= 1'b0;
          occ        <= occ - OCC_W'(1);
          drops      <= drops + 17'd1;
        end else if (!found ||
                     (policy == POLICY_BD ? aged_rank > best_rank
                                          : aged_rank < best_rank)) begin
          found     <= 1'b1;
          best      <= idx;
          best_rank <= aged_rank;
        end
      end
      if (cmd.finish) begin
        dropped_now   <= drops_sum;
        total_dropped <= total_dropped + 32'(drops_sum);
        if (tick && found) begin
          valid[best] <= 1'b0;
          occ         <= occ - OCC_W'(1);
          sent        <= 1'b1;
          sent_value  <= best_val;
          total_sent  <= total_sent + 32'd1;
          total_value <= total_value + 32'(best_val);
        end else begin
          sent       <= 1'b0;
          sent_value <= '0;
        end
      end
    end
  end

  assign occupancy = 5'(occ);

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    32'(occ) <= DEPTH)
    else $error("occupancy above depth");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.finish))
    else $error("result strobe without finish");
  a_evict_found: assert property (@(posedge clk) disable iff (rst)
    cmd.ev_write |-> (found && valid[best]))
    else $error("eviction of an empty entry");

endmodule
